[src/vmhp_pkg.sv]
// Package for the valve motor homing positioner.
// Holds the phase encoding, the register map, and the item, result and configuration bundles.
// No dependencies.
package vmhp_pkg;

  // Field widths
  localparam int unsigned TickW  = 16;
  localparam int unsigned SpanW  = 15;
  localparam int unsigned PctW   = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned BlankW = 8;
  localparam int unsigned DbandW = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Saturation limits
  localparam logic [TickW-1:0]       TickSatMax = 16'd32767;
  localparam logic signed [PosW-1:0] PosMax     = 16'sh7fff;
  localparam logic signed [PosW-1:0] PosMin     = 16'sh8000;

  // Reset values of the configuration registers
  localparam logic [TickW-1:0]  StartupDelayRst = 16'd192;
  localparam logic [BlankW-1:0] BlankingRst     = 8'd32;
  localparam logic [DbandW-1:0] DeadbandRst     = 10'd16;

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_STARTUP_DELAY = 2'd0,
    REG_BLANKING      = 2'd1,
    REG_DEADBAND      = 2'd2
  } cfg_reg_t;

  // Request kinds
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_TARGET = 1'b1
  } op_t;

  // Controller phases, one-hot
  typedef enum logic [7:0] {
    M_PREINIT = 8'b0000_0001,
    M_INIT    = 8'b0000_0010,
    M_HOME1   = 8'b0000_0100,
    M_HOME2   = 8'b0000_1000,
    M_WAIT    = 8'b0001_0000,
    M_DOWN    = 8'b0010_0000,
    M_ZERO    = 8'b0100_0000,
    M_UP      = 8'b1000_0000
  } mode_t;

  // Phase codes seen on the result port
  localparam logic [2:0] PH_PREINIT = 3'd0;
  localparam logic [2:0] PH_INIT    = 3'd1;
  localparam logic [2:0] PH_HOME1   = 3'd2;
  localparam logic [2:0] PH_HOME2   = 3'd3;
  localparam logic [2:0] PH_WAIT    = 3'd4;
  localparam logic [2:0] PH_DOWN    = 3'd5;
  localparam logic [2:0] PH_ZERO    = 3'd6;
  localparam logic [2:0] PH_UP      = 3'd7;

  typedef struct packed {
    logic [TickW-1:0]  startup_delay;
    logic [BlankW-1:0] blanking_ticks;
    logic [DbandW-1:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic            operation;
    logic            end_stop;
    logic [PctW-1:0] target_percent;
  } item_t;

  typedef struct packed {
    logic                   motor_fwd;
    logic                   motor_rev;
    logic [2:0]             phase;
    logic signed [PosW-1:0] position;
    logic signed [PosW-1:0] target_position;
    logic [SpanW-1:0]       calibrated_span;
  } result_t;

  function automatic logic [2:0] phase_code(mode_t m);
    logic [2:0] code;
    case (m)
      M_PREINIT: code = PH_PREINIT;
      M_INIT:    code = PH_INIT;
      M_HOME1:   code = PH_HOME1;
      M_HOME2:   code = PH_HOME2;
      M_WAIT:    code = PH_WAIT;
      M_DOWN:    code = PH_DOWN;
      M_ZERO:    code = PH_ZERO;
      M_UP:      code = PH_UP;
      default:   code = PH_PREINIT;
    endcase
    return code;
  endfunction

endpackage

[src/vmhp_cfg.sv]
// Configuration register file of the valve positioner.
// Depends on vmhp_pkg for the register map and the cfg_t bundle.
module vmhp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vmhp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vmhp_pkg::CfgDataW-1:0]  cfg_data,
  output vmhp_pkg::cfg_t                 cfg
);
  import vmhp_pkg::*;

  cfg_t regs;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.startup_delay  <= StartupDelayRst;
      regs.blanking_ticks <= BlankingRst;
      regs.deadband       <= DeadbandRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STARTUP_DELAY: regs.startup_delay  <= cfg_data;
        REG_BLANKING:      regs.blanking_ticks <= cfg_data[BlankW-1:0];
        REG_DEADBAND:      regs.deadband       <= cfg_data[DbandW-1:0];
        default:           ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[src/vmhp_core.sv]
// Controller state and one-request step logic of the valve positioner.
// Depends on vmhp_pkg; state advances when fire is high, result shows the state after the step.
module vmhp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  vmhp_pkg::item_t   item,
  input  vmhp_pkg::cfg_t    cfg,
  output vmhp_pkg::result_t result
);
  import vmhp_pkg::*;

  // State registers
  mode_t                  mode;
  logic [TickW-1:0]       tick_count;
  logic [SpanW-1:0]       span;
  logic signed [PosW-1:0] current_pos;
  logic [SpanW-1:0]       wanted_pos;
  logic [PctW-1:0]        wanted_percent;
  logic                   drive_plus;
  logic                   drive_minus;

  mode_t                  mode_next;
  logic [TickW-1:0]       tick_count_next;
  logic [SpanW-1:0]       span_next;
  logic signed [PosW-1:0] current_pos_next;
  logic [SpanW-1:0]       wanted_pos_next;
  logic [PctW-1:0]        wanted_percent_next;
  logic                   drive_plus_next;
  logic                   drive_minus_next;

  // Shared target multiplier: span times percent
  logic [TickW-1:0]       home_count;
  logic [SpanW-1:0]       mul_span;
  logic [PctW-1:0]        mul_pct;
  logic [SpanW+PctW-1:0]  product;
  logic [SpanW-1:0]       product_pos;

  // Saturating homing count
  assign home_count = (tick_count < TickSatMax) ? tick_count + 16'd1 : tick_count;
  assign mul_span   = (item.operation == OP_TARGET) ? span : home_count[SpanW-1:0];
  assign mul_pct    = (item.operation == OP_TARGET) ? item.target_percent : wanted_percent;
  assign product    = mul_span * mul_pct;
  assign product_pos = product[SpanW+PctW-1:PctW];

  // Next-state logic
  always_comb begin
    logic signed [17:0] want_ext;
    logic signed [17:0] db_ext;
    logic signed [17:0] pos_ext;
    logic signed [17:0] want_ext_n;
    logic signed [PosW-1:0] pos_dn;
    logic signed [PosW-1:0] pos_up;

    mode_next           = mode;
    tick_count_next     = tick_count;
    span_next           = span;
    current_pos_next    = current_pos;
    wanted_pos_next     = wanted_pos;
    wanted_percent_next = wanted_percent;
    drive_plus_next     = drive_plus;
    drive_minus_next    = drive_minus;

    want_ext   = $signed({3'b000, wanted_pos});
    db_ext     = $signed({8'd0, cfg.deadband});
    pos_ext    = {{2{current_pos[PosW-1]}}, current_pos};
    want_ext_n = want_ext - db_ext;
    pos_dn     = (current_pos != PosMin) ? current_pos - 16'sd1 : current_pos;
    pos_up     = (current_pos != PosMax) ? current_pos + 16'sd1 : current_pos;

    if (item.operation == OP_TARGET) begin
      // Target write: no time passes
      wanted_percent_next = item.target_percent;
      if (span != '0) begin
        wanted_pos_next = product_pos;
      end
    end else begin
      case (mode)
        M_PREINIT: begin
          tick_count_next  = cfg.startup_delay;
          current_pos_next = -16'sd1;
          span_next        = '0;
          mode_next        = M_INIT;
        end
        M_INIT: begin
          if (tick_count <= 16'd1) begin
            mode_next       = M_HOME1;
            tick_count_next = {8'd0, cfg.blanking_ticks};
            drive_plus_next = 1'b1;
          end else begin
            tick_count_next = tick_count - 16'd1;
          end
        end
        M_HOME1: begin
          if (tick_count != '0) begin
            tick_count_next = tick_count - 16'd1;
          end else if (item.end_stop) begin
            drive_plus_next  = 1'b0;
            drive_minus_next = 1'b1;
            mode_next        = M_HOME2;
          end
        end
        M_HOME2: begin
          tick_count_next = home_count;
          if (home_count > {8'd0, cfg.blanking_ticks} && item.end_stop) begin
            drive_minus_next = 1'b0;
            mode_next        = M_WAIT;
            span_next        = home_count[SpanW-1:0];
            current_pos_next = '0;
            wanted_pos_next  = product_pos;
          end
        end
        M_WAIT: begin
          if (want_ext_n > pos_ext) begin
            tick_count_next  = {8'd0, cfg.blanking_ticks};
            drive_minus_next = 1'b0;
            drive_plus_next  = 1'b1;
            mode_next        = M_UP;
          end else if (want_ext + db_ext < pos_ext) begin
            tick_count_next  = {8'd0, cfg.blanking_ticks};
            drive_plus_next  = 1'b0;
            drive_minus_next = 1'b1;
            mode_next        = (wanted_pos < (span >> 3)) ? M_ZERO : M_DOWN;
          end
        end
        M_ZERO: begin
          current_pos_next = pos_dn;
          if (tick_count != '0) begin
            tick_count_next = tick_count - 16'd1;
          end else if (item.end_stop) begin
            drive_plus_next  = 1'b0;
            drive_minus_next = 1'b0;
            current_pos_next = '0;
            mode_next        = M_WAIT;
          end
        end
        M_DOWN: begin
          current_pos_next = pos_dn;
          if (tick_count != '0) begin
            tick_count_next = tick_count - 16'd1;
          end else if (item.end_stop) begin
            current_pos_next = '0;
          end
          // Stop on reaching the target or the zero stop
          if (current_pos_next <= $signed({1'b0, wanted_pos})) begin
            drive_plus_next  = 1'b0;
            drive_minus_next = 1'b0;
            mode_next        = M_WAIT;
          end
        end
        M_UP: begin
          current_pos_next = pos_up;
          if (tick_count != '0) begin
            tick_count_next = tick_count - 16'd1;
          end else if (item.end_stop) begin
            drive_plus_next  = 1'b0;
            drive_minus_next = 1'b0;
            current_pos_next = $signed({1'b0, span});
            mode_next        = M_WAIT;
          end
          if (current_pos_next >= $signed({1'b0, wanted_pos})) begin
            drive_plus_next  = 1'b0;
            drive_minus_next = 1'b0;
            mode_next        = M_WAIT;
          end
        end
        default: begin
          mode_next = M_PREINIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_PREINIT;
      tick_count     <= '0;
      span           <= '0;
      current_pos    <= '0;
      wanted_pos     <= '0;
      wanted_percent <= '0;
      drive_plus     <= 1'b0;
      drive_minus    <= 1'b0;
    end else if (fire) begin
      mode           <= mode_next;
      tick_count     <= tick_count_next;
      span           <= span_next;
      current_pos    <= current_pos_next;
      wanted_pos     <= wanted_pos_next;
      wanted_percent <= wanted_percent_next;
      drive_plus     <= drive_plus_next;
      drive_minus    <= drive_minus_next;
    end
  end

  // State after this step
  always_comb begin
    result.motor_fwd       = drive_plus_next;
    result.motor_rev       = drive_minus_next;
    result.phase           = phase_code(mode_next);
    result.position        = current_pos_next;
    result.target_position = $signed({1'b0, wanted_pos_next});
    result.calibrated_span = span_next;
  end

endmodule

[src/valve_motor_homing_positioner.sv]
// Top level of the valve motor homing positioner.
// Depends on vmhp_pkg, vmhp_cfg and vmhp_core; holds the request and result registers.
//
// Usage:
//   Request channel (item_valid / item_stall): a tick carrying end_stop, or a
//   target write carrying target_percent, selected by operation.
//   Result channel (result_valid / result_stall): one result per request with
//   the motor drives, phase, position, target position and calibrated span
//   as they stand after that request.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always
//   ready; index 0 startup delay, 1 blanking ticks, 2 deadband. Write only
//   while no request is in flight.
// Timing: a request is registered on acceptance and its result is registered
//   when the step stage fires. One request per cycle is taken while the result
//   is not stalled; the step logic is a single pass with one 15x8 multiply.
// Reset: synchronous; the configuration, controller and valid registers return to
//   their defaults, the controller goes to preinit and its motor drives are off.
// Stall: a held result blocks the step stage; the request register then holds
//   its request and item_stall rises until the result is taken.
module valve_motor_homing_positioner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                operation,
  input  logic                                end_stop,
  input  logic [vmhp_pkg::PctW-1:0]           target_percent,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                motor_fwd,
  output logic                                motor_rev,
  output logic [2:0]                          phase,
  output logic signed [vmhp_pkg::PosW-1:0]    position,
  output logic signed [vmhp_pkg::PosW-1:0]    target_position,
  output logic [vmhp_pkg::SpanW-1:0]          calibrated_span,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vmhp_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [vmhp_pkg::CfgDataW-1:0]       cfg_data
);
  import vmhp_pkg::*;

  cfg_t    cfg;
  item_t   req;
  logic    req_valid;
  result_t step_result;
  result_t res;
  logic    res_valid;
  logic    fire;

  vmhp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Step stage advances when the result register is free or being drained
  assign fire       = req_valid && (!res_valid || !result_stall);
  assign item_stall = req_valid && res_valid && result_stall;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!item_stall) begin
      req_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      req.operation      <= operation;
      req.end_stop       <= end_stop;
      req.target_percent <= target_percent;
    end
  end

  vmhp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (req),
    .cfg    (cfg),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!result_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_result;
    end
  end

  assign result_valid    = res_valid;
  assign motor_fwd       = res.motor_fwd;
  assign motor_rev       = res.motor_rev;
  assign phase           = res.phase;
  assign position        = res.position;
  assign target_position = res.target_position;
  assign calibrated_span = res.calibrated_span;

endmodule

[tb/tb_top.sv]
// Self-checking bench for valve_motor_homing_positioner: homing, target tracking and end-stop
// re-anchoring, checked against an in-bench predictor of the controller.
// Depends on vmhp_pkg and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vmhp_pkg::*;

  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 8;
  localparam int QuietLimit   = 1000;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic clk;
  logic rst = 1'b1;

  // request channel
  logic item_valid = 1'b0;
  logic item_stall;
  logic operation = 1'b0;
  logic end_stop = 1'b0;
  logic [PctW-1:0] target_percent = '0;

  // result channel
  logic result_valid;
  logic result_stall = 1'b0;
  logic motor_fwd;
  logic motor_rev;
  logic [2:0] phase;
  logic signed [PosW-1:0] position;
  logic signed [PosW-1:0] target_position;
  logic [SpanW-1:0] calibrated_span;

  // register write channel
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  valve_motor_homing_positioner DUT (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .operation       (operation),
    .end_stop        (end_stop),
    .target_percent  (target_percent),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .motor_fwd       (motor_fwd),
    .motor_rev       (motor_rev),
    .phase           (phase),
    .position        (position),
    .target_position (target_position),
    .calibrated_span (calibrated_span),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // predicted controller state and register copies
  logic [2:0]             valve_phase;
  logic [TickW-1:0]       valve_count;
  logic [SpanW-1:0]       valve_span;
  logic signed [PosW-1:0] valve_pos;
  logic signed [PosW-1:0] valve_goal;
  logic [PctW-1:0]        valve_pct;
  logic                   drive_up;
  logic                   drive_down;
  logic [TickW-1:0]       cfg_startup;
  logic [BlankW-1:0]      cfg_blank;
  logic [DbandW-1:0]      cfg_dband;

  item_t   pending_req_q[$];
  result_t expected_status_q[$];
  item_t   req_now;
  result_t seen_status;
  result_t due_status;
  int      send_gap = 0;
  int      stall_left = 0;
  int      queued_count = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      calm = 1'b0;

  // Advance the predicted controller by one request; returns the status it should report.
  function automatic result_t advance_valve(item_t req);
    int pos, goal, spn, db;
    bit moving_down;
    result_t res;
    pos = int'(valve_pos);
    goal = int'(valve_goal);
    spn = int'(valve_span);
    db = int'(cfg_dband);
    if (req.operation == OP_TARGET) begin
      // target write: no time passes, goal only follows once calibrated
      valve_pct = req.target_percent;
      if (spn != 0) goal = int'((spn * valve_pct) >> 8);
    end else begin
      case (valve_phase)
        PH_PREINIT: begin
          valve_count = cfg_startup;
          pos = -1;
          spn = 0;
          valve_phase = PH_INIT;
        end
        PH_INIT: begin
          if (valve_count <= 1) begin
            valve_phase = PH_HOME1;
            valve_count = TickW'(cfg_blank);
            drive_up = 1'b1;
          end else begin
            valve_count--;
          end
        end
        PH_HOME1: begin
          if (valve_count > 0) begin
            valve_count--;
          end else if (req.end_stop) begin
            drive_up = 1'b0;
            drive_down = 1'b1;
            valve_phase = PH_HOME2;
          end
        end
        PH_HOME2: begin
          // span count saturates
          if (valve_count < TickSatMax) valve_count++;
          if (valve_count > cfg_blank && req.end_stop) begin
            drive_down = 1'b0;
            valve_phase = PH_WAIT;
            spn = int'(valve_count);
            pos = 0;
            goal = int'((spn * valve_pct) >> 8);
          end
        end
        PH_WAIT: begin
          if (goal - db > pos) begin
            valve_count = TickW'(cfg_blank);
            drive_down = 1'b0;
            drive_up = 1'b1;
            valve_phase = PH_UP;
          end else if (goal + db < pos) begin
            valve_count = TickW'(cfg_blank);
            drive_up = 1'b0;
            drive_down = 1'b1;
            valve_phase = (goal < (spn >>> 3)) ? PH_ZERO : PH_DOWN;
          end
        end
        PH_ZERO, PH_DOWN: begin
          moving_down = (valve_phase == PH_DOWN);
          if (pos > -32768) pos--;
          if (valve_count > 0) begin
            valve_count--;
          end else if (req.end_stop) begin
            drive_up = 1'b0;
            drive_down = 1'b0;
            pos = 0;
            valve_phase = PH_WAIT;
          end
          if (moving_down && pos <= goal) begin
            drive_up = 1'b0;
            drive_down = 1'b0;
            valve_phase = PH_WAIT;
          end
        end
        default: begin
          // running up
          if (pos < 32767) pos++;
          if (valve_count > 0) begin
            valve_count--;
          end else if (req.end_stop) begin
            drive_up = 1'b0;
            drive_down = 1'b0;
            pos = spn;
            valve_phase = PH_WAIT;
          end
          if (pos >= goal) begin
            drive_up = 1'b0;
            drive_down = 1'b0;
            valve_phase = PH_WAIT;
          end
        end
      endcase
    end
    valve_pos = PosW'(pos);
    valve_goal = PosW'(goal);
    valve_span = SpanW'(spn);
    res.motor_fwd = drive_up;
    res.motor_rev = drive_down;
    res.phase = valve_phase;
    res.position = valve_pos;
    res.target_position = valve_goal;
    res.calibrated_span = valve_span;
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver: takes pending requests, random gap bursts after a send
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) expected_status_q.push_back(advance_valve(req_now));
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          req_now = pending_req_q.pop_front();
          operation <= req_now.operation;
          end_stop <= req_now.end_stop;
          target_percent <= req_now.target_percent;
          item_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        seen_status = {motor_fwd, motor_rev, phase, position, target_position,
                       calibrated_span};
        if (expected_status_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          due_status = expected_status_q.pop_front();
          check_field("motor_fwd", due_status.motor_fwd, seen_status.motor_fwd);
          check_field("motor_rev", due_status.motor_rev, seen_status.motor_rev);
          check_field("phase", due_status.phase, seen_status.phase);
          check_field("position", int'($signed(due_status.position)),
                      int'($signed(seen_status.position)));
          check_field("target_position", int'($signed(due_status.target_position)),
                      int'($signed(seen_status.target_position)));
          check_field("calibrated_span", due_status.calibrated_span,
                      seen_status.calibrated_span);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_tick(bit stop);
    item_t r;
    r.operation = OP_TICK;
    r.end_stop = stop;
    r.target_percent = PctW'($urandom);
    pending_req_q.push_back(r);
    queued_count++;
  endtask

  task automatic queue_target(logic [PctW-1:0] pct);
    item_t r;
    r.operation = OP_TARGET;
    r.end_stop = 1'($urandom_range(0, 1));
    r.target_percent = pct;
    pending_req_q.push_back(r);
    queued_count++;
  endtask

  // n free-running ticks, optionally closed by an end-stop tick
  task automatic queue_run(int n, bit stop_at_end);
    repeat (n) queue_tick(1'b0);
    if (stop_at_end) queue_tick(1'b1);
  endtask

  // wait until every request is sent and answered, then let the pipeline empty
  task automatic wait_settled();
    do @(negedge clk);
    while (pending_req_q.size() != 0 || item_valid || expected_status_q.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_STARTUP_DELAY: cfg_startup = data;
      REG_BLANKING:      cfg_blank = data[BlankW-1:0];
      REG_DEADBAND:      cfg_dband = data[DbandW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Episodes: optional target write and run ending on a stop, by count or in noise; or noise.
  task automatic random_phase(int budget);
    int start, kind, pct, base, n;
    start = queued_count;
    while (queued_count - start < budget) begin
      wait_settled();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // unstructured requests
        repeat (8) begin
          if ($urandom_range(0, 1)) queue_target(PctW'($urandom));
          else queue_tick(1'($urandom_range(0, 1)));
        end
      end else begin
        if (valve_phase == PH_WAIT || $urandom_range(0, 3) == 0) begin
          base = (valve_span == 0) ? 0 : (int'(valve_pos) * 256) / int'(valve_span);
          case ($urandom_range(0, 2))
            0: pct = $urandom_range(0, 255);
            1: pct = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(253, 255);
            default: pct = base + int'($urandom_range(0, 4)) - 2;
          endcase
          if (pct < 0) pct = 0;
          else if (pct > 255) pct = 255;
          queue_target(pct[PctW-1:0]);
        end
        case (kind % 3)
          0: queue_run(int'(cfg_blank) + int'($urandom_range(0, 6)), 1'b1);
          1: queue_run($urandom_range(1, 160), 1'b0);
          default: begin
            n = $urandom_range(0, int'(cfg_blank) + 40);
            repeat (n) queue_tick($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    valve_phase = PH_PREINIT;
    valve_count = '0;
    valve_span = '0;
    valve_pos = '0;
    valve_goal = '0;
    valve_pct = '0;
    drive_up = 1'b0;
    drive_down = 1'b0;
    cfg_startup = StartupDelayRst;
    cfg_blank = BlankingRst;
    cfg_dband = DeadbandRst;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // startup delay only matters before the first tick; last write wins
    write_reg(REG_STARTUP_DELAY, 16'hFFFF);
    write_reg(REG_STARTUP_DELAY, CfgDataW'($urandom_range(0, 2)));
    write_reg(REG_BLANKING, 16'd3);
    write_reg(REG_DEADBAND, 16'd16);

    // homing, with target writes before calibration and stops inside blanking
    queue_target(8'd255);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_target(8'd64);
    queue_tick(1'b1);
    queue_run(3, 1'b1);
    queue_tick(1'b1);
    queue_tick(1'b1);
    // longer span count before the far stop
    queue_run(60, 1'b0);
    queue_target(8'd255);
    queue_tick(1'b1);

    // target equal to position, short move up by count
    queue_target(8'd0);
    queue_tick(1'b0);
    queue_target(8'd1);
    queue_run(40, 1'b0);
    // run to zero past the stop position, then the stop
    queue_target(8'd0);
    queue_run(80, 1'b1);
    // run up into the far stop, then down by count with a write mid-move
    queue_target(8'd255);
    queue_run(5, 1'b1);
    queue_target(8'd250);
    queue_run(60, 1'b0);
    queue_target(8'd248);
    queue_run(80, 1'b0);
    wait_settled();

    write_reg(REG_BLANKING, CfgDataW'($urandom_range(0, 20)));
    write_reg(REG_DEADBAND, CfgDataW'($urandom_range(0, 64)));
    random_phase(200);
    wait_settled();

    write_reg(REG_BLANKING, 16'd0);
    write_reg(REG_DEADBAND, 16'd0);
    random_phase(150);
    wait_settled();

    // upper data bits beyond the register widths are don't-care
    write_reg(REG_BLANKING, CfgDataW'($urandom) | 16'h00FF);
    write_reg(REG_DEADBAND, CfgDataW'($urandom) | 16'h03FF);
    random_phase(100);
    wait_settled();

    write_reg(REG_STARTUP_DELAY, 16'd1);
    write_reg(RegSpare, CfgDataW'($urandom));
    write_reg(REG_BLANKING, CfgDataW'(BlankingRst));
    write_reg(REG_DEADBAND, CfgDataW'(DeadbandRst));
    // closing stretch at full rate on both sides
    calm = 1'b1;
    random_phase(150);
    wait_settled();

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
